@@ rtl/spa_pkg.sv @@
`timescale 1ns / 1ps
// Shared palette allocator: common types and codes.
// No dependencies; imported by spa_cell and shared_palette_allocator_core.
package spa_pkg;

	localparam int COLOR_W = 16;
	localparam int REFCNT_W = 8;
	localparam int IDX_W = 4;
	localparam int STATUS_W = 2;

	localparam logic [REFCNT_W-1:0] REFCNT_MAX = '1;

	localparam logic [STATUS_W-1:0] ST_REUSED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FILLED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd3;

	localparam logic ACT_COLOR = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef logic [COLOR_W-1:0] color_t;

	typedef struct packed {
		logic col_we;
		logic restart;
		color_t color;
		logic inc;
		logic dec;
		logic fill;
	} cell_ctrl_t;

	typedef struct packed {
		logic zero_seen;
		logic found;
	} chain_t;

endpackage

@@ rtl/shared_palette_allocator_core.sv @@
`timescale 1ns / 1ps
// Shared palette allocator top level: staging, control and a row of palette cells.
// Depends on spa_pkg and spa_cell.
//
// Usage: items enter on the req channel (req_valid/req_ready). A color item
// (action 0) is staged and compared against every palette in the same cycle;
// a release item (action 1) lowers one palette's count. Neither gives a result
// unless last_color is set on a color item.
// The item that ends a load request is accepted; a scan cycle follows (once the
// result register is free) in which the cell chain picks the free candidate and
// the first matching palette, fills the free one if needed and bumps its
// count, unless too many colors were staged. Other items need no scan. The result
// appears on the res channel (res_valid/res_ready) the cycle after the scan.
// req_ready is low only while a scan waits or runs. While a result waits for
// res_ready, further items are still taken; a new scan waits until the
// result register is free, holding req_ready low.
// Reset clears all palettes, counts, staging count and the overflow flag.
module shared_palette_allocator_core #(
	parameter int PALETTE_COUNT = 16,
	parameter int COLORS_PER_PALETTE = 15
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic                           action,
	input  spa_pkg::color_t                color_value,
	input  logic                           last_color,
	input  logic [spa_pkg::IDX_W-1:0]      release_index,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [spa_pkg::IDX_W-1:0]      chosen_palette,
	output logic [spa_pkg::STATUS_W-1:0]   status
);
	import spa_pkg::*;

	localparam int PW = $clog2(PALETTE_COUNT);
	localparam int CW = $clog2(COLORS_PER_PALETTE + 1);
	localparam int IW = (COLORS_PER_PALETTE > 1) ? $clog2(COLORS_PER_PALETTE) : 1;

	color_t stage_q [COLORS_PER_PALETTE];
	logic [CW-1:0] stg_cnt_q;
	logic ovf_q;
	logic busy_q;
	logic res_valid_q;
	logic [IDX_W-1:0] chosen_q;
	logic [STATUS_W-1:0] status_q;

	logic req_acc;
	logic col_acc;
	logic col_we;
	logic rel_acc;
	logic rel_ok;
	logic [31:0] rel_wide;
	logic [PW-1:0] rel_idx;
	logic scan_go;
	logic any_hit;
	logic any_free;
	logic [PW-1:0] hit_idx;
	logic [PW-1:0] free_idx;
	logic [31:0] pick_wide;
	logic [PALETTE_COUNT-1:0] hit_vec;
	logic [PALETTE_COUNT-1:0] free_vec;
	cell_ctrl_t ctrl_v [PALETTE_COUNT];
	chain_t chain_v [PALETTE_COUNT+1];

	assign req_ready = !busy_q;
	assign req_acc = req_valid && req_ready;
	assign col_acc = req_acc && (action == ACT_COLOR);
	assign col_we = col_acc && (stg_cnt_q < CW'(COLORS_PER_PALETTE));
	assign rel_acc = req_acc && (action == ACT_RELEASE);
	assign rel_wide = 32'(release_index);
	assign rel_ok = rel_wide < PALETTE_COUNT;
	assign rel_idx = rel_wide[PW-1:0];
	assign scan_go = busy_q && (!res_valid_q || res_ready);

	assign chain_v[0] = '0;
	assign any_hit = chain_v[PALETTE_COUNT].found;
	assign any_free = |free_vec;

	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		for (int p = 0; p < PALETTE_COUNT; p++) begin
			if (hit_vec[p]) hit_idx = hit_idx | PW'(p);
			if (free_vec[p]) free_idx = free_idx | PW'(p);
		end
	end

	always_comb begin
		for (int p = 0; p < PALETTE_COUNT; p++) begin
			ctrl_v[p].col_we = col_we;
			ctrl_v[p].restart = (stg_cnt_q == '0);
			ctrl_v[p].color = color_value;
			ctrl_v[p].inc = scan_go && !ovf_q && (hit_vec[p] || (!any_hit && free_vec[p]));
			ctrl_v[p].dec = rel_acc && rel_ok && (rel_idx == PW'(p));
			ctrl_v[p].fill = scan_go && !ovf_q && !any_hit && free_vec[p];
		end
	end

	for (genvar g = 0; g < PALETTE_COUNT; g++) begin : g_cell
		spa_cell #(
			.COLORS(COLORS_PER_PALETTE),
			.CW(CW),
			.IW(IW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl_v[g]),
			.rd_idx(stg_cnt_q[IW-1:0]),
			.stage(stage_q),
			.fill_n(stg_cnt_q),
			.chain_in(chain_v[g]),
			.chain_out(chain_v[g+1]),
			.hit(hit_vec[g]),
			.is_free(free_vec[g])
		);
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			stage_q[stg_cnt_q[IW-1:0]] <= color_value;
		end
	end

	assign pick_wide = any_hit ? 32'(hit_idx) : 32'(free_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_cnt_q <= '0;
			ovf_q <= 1'b0;
			busy_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (col_we) begin
				stg_cnt_q <= stg_cnt_q + 1'b1;
			end else if (col_acc) begin
				ovf_q <= 1'b1;
			end
			if (col_acc && last_color) begin
				busy_q <= 1'b1;
			end
			if (scan_go) begin
				stg_cnt_q <= '0;
				ovf_q <= 1'b0;
				busy_q <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_go) begin
			priority if (ovf_q) begin
				status_q <= ST_TOO_MANY;
				chosen_q <= '0;
			end else if (any_hit || any_free) begin
				status_q <= any_hit ? ST_REUSED : ST_FILLED;
				chosen_q <= pick_wide[IDX_W-1:0];
			end else begin
				status_q <= ST_NONE;
				chosen_q <= '0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign chosen_palette = chosen_q;
	assign status = status_q;

`ifndef SYNTHESIS
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(hit_vec))
		else $error("more than one palette hit");
	a_free_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(free_vec))
		else $error("more than one free candidate");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stg_cnt_q <= CW'(COLORS_PER_PALETTE))
		else $error("staging count beyond palette size");
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(col_acc && last_color) |=> busy_q)
		else $error("completion did not start a scan");
	a_scan_res: assert property (@(posedge clk) disable iff (!arst_n)
		scan_go |=> (res_valid_q && !busy_q && stg_cnt_q == '0 && !ovf_q))
		else $error("scan did not produce a result and clear staging");
`endif

endmodule

@@ rtl/spa_cell.sv @@
`timescale 1ns / 1ps
// One palette cell: colors, reference count, running match flag, scan chain link.
// Depends on spa_pkg.
module spa_cell #(
	parameter int COLORS = 15,
	parameter int CW = 4,
	parameter int IW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spa_pkg::cell_ctrl_t ctrl,
	input  logic [IW-1:0]       rd_idx,
	input  spa_pkg::color_t     stage [COLORS],
	input  logic [CW-1:0]       fill_n,
	input  spa_pkg::chain_t     chain_in,
	output spa_pkg::chain_t     chain_out,
	output logic                hit,
	output logic                is_free
);
	import spa_pkg::*;

	color_t colors_q [COLORS];
	logic [REFCNT_W-1:0] cnt_q;
	logic match_q;
	logic cnt_zero;
	logic eq;

	assign cnt_zero = (cnt_q == '0);
	assign eq = (colors_q[rd_idx] == ctrl.color);
	assign is_free = cnt_zero && !chain_in.zero_seen;
	assign hit = match_q && !is_free && !chain_in.found;
	assign chain_out.zero_seen = chain_in.zero_seen || cnt_zero;
	assign chain_out.found = chain_in.found || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COLORS; i++) begin
				colors_q[i] <= '0;
			end
		end else if (ctrl.fill) begin
			for (int i = 0; i < COLORS; i++) begin
				if (i < int'(fill_n)) begin
					colors_q[i] <= stage[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.col_we) begin
				match_q <= (ctrl.restart || match_q) && eq;
			end
			if (ctrl.inc && cnt_q != REFCNT_MAX) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctrl.dec && !cnt_zero) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
